// ===== sv/cmts_pkg.sv =====
// ----------------------------------------------------------------------------
// C-minus token scanner package
// Token kinds, scanner states, character codes and keyword tables.
// ----------------------------------------------------------------------------
package cmts_pkg;

  localparam int MAX_TOKEN_LENGTH_DEF = 40;
  localparam int FIFO_DEPTH           = 4;
  localparam int KW_NUM               = 6;
  localparam int LEN_W                = 6;
  localparam int LINE_W               = 16;

  typedef enum logic [4:0] {
    TOK_ENDFILE  = 5'd0,
    TOK_ERROR    = 5'd1,
    TOK_IF       = 5'd2,
    TOK_ELSE     = 5'd3,
    TOK_INT      = 5'd4,
    TOK_RETURN   = 5'd5,
    TOK_VOID     = 5'd6,
    TOK_WHILE    = 5'd7,
    TOK_ID       = 5'd8,
    TOK_NUM      = 5'd9,
    TOK_ASSIGN   = 5'd10,
    TOK_EQ       = 5'd11,
    TOK_NE       = 5'd12,
    TOK_LT       = 5'd13,
    TOK_LE       = 5'd14,
    TOK_GT       = 5'd15,
    TOK_GE       = 5'd16,
    TOK_PLUS     = 5'd17,
    TOK_MINUS    = 5'd18,
    TOK_TIMES    = 5'd19,
    TOK_OVER     = 5'd20,
    TOK_LPAREN   = 5'd21,
    TOK_RPAREN   = 5'd22,
    TOK_LBRACKET = 5'd23,
    TOK_RBRACKET = 5'd24,
    TOK_LBRACE   = 5'd25,
    TOK_RBRACE   = 5'd26,
    TOK_SEMI     = 5'd27,
    TOK_COMMA    = 5'd28
  } tok_kind_e;

  typedef enum logic [3:0] {
    ST_START    = 4'd0,
    ST_LT       = 4'd1,
    ST_GT       = 4'd2,
    ST_EQ       = 4'd3,
    ST_BANG     = 4'd4,
    ST_SLASH    = 4'd5,
    ST_COMMENT  = 4'd6,
    ST_COMMSTAR = 4'd7,
    ST_NUM      = 4'd8,
    ST_ID       = 4'd9
  } scan_state_e;

  typedef struct packed {
    tok_kind_e          kind;
    logic [LEN_W-1:0]   length;
    logic [LINE_W-1:0]  line;
    logic               last;
  } token_t;

  // tok0 is the first token of the request; count says how many are valid
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } scan_res_t;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;

  // keyword spellings: if, else, int, return, void, while
  localparam logic [7:0] KW_TEXT [KW_NUM][8] = '{
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E, 8'h00, 8'h00},
    '{8'h76, 8'h6F, 8'h69, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd2, 3'd4, 3'd3, 3'd6, 3'd4, 3'd5};

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_NL};
  endfunction

  function automatic tok_kind_e single_kind(input logic [7:0] c);
    tok_kind_e k;
    case (c)
      CH_PLUS:  k = TOK_PLUS;
      CH_MINUS: k = TOK_MINUS;
      CH_STAR:  k = TOK_TIMES;
      CH_LPAR:  k = TOK_LPAREN;
      CH_RPAR:  k = TOK_RPAREN;
      CH_LBRK:  k = TOK_LBRACKET;
      CH_RBRK:  k = TOK_RBRACKET;
      CH_LBRC:  k = TOK_LBRACE;
      CH_RBRC:  k = TOK_RBRACE;
      CH_SEMI:  k = TOK_SEMI;
      CH_COMMA: k = TOK_COMMA;
      default:  k = TOK_ERROR;
    endcase
    return k;
  endfunction

endpackage

// ===== sv/cmts_core.sv =====
// ----------------------------------------------------------------------------
// C-minus scanner core
// Scanner state, token length, keyword flags and line counter, with the
// first-pass and rescan next-state logic that yields up to two tokens per request.
// ----------------------------------------------------------------------------
module cmts_core #(
  parameter int MAX_TOKEN_LENGTH = cmts_pkg::MAX_TOKEN_LENGTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          ch_i,
  input  logic                eof_i,
  output cmts_pkg::scan_res_t res_o
);

  localparam int CNT_W = $clog2(MAX_TOKEN_LENGTH + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TOKEN_LENGTH);
  localparam logic [cmts_pkg::KW_NUM-1:0] KM_ALL = '1;

  typedef struct packed {
    logic                  emit;
    cmts_pkg::tok_kind_e   kind;
    logic [CNT_W-1:0]      len;
    cmts_pkg::scan_state_e state;
    logic [CNT_W-1:0]      cnt;
    logic [cmts_pkg::KW_NUM-1:0] km;
  } pass_t;

  cmts_pkg::scan_state_e             state_q, state_d;
  logic [CNT_W-1:0]                  cnt_q, cnt_d;
  logic [cmts_pkg::KW_NUM-1:0]       km_q, km_d;
  logic [cmts_pkg::LINE_W-1:0]       line_q, line_d;

  pass_t sp;
  pass_t p1;
  logic  rescan;
  logic  two;

  // drop keyword flags that the letter c at position cnt rules out
  function automatic logic [cmts_pkg::KW_NUM-1:0] match_letter(
    input logic [cmts_pkg::KW_NUM-1:0] km,
    input logic [CNT_W-1:0]            cnt,
    input logic [7:0]                  c
  );
    logic [cmts_pkg::KW_NUM-1:0] r;
    r = km;
    for (int k = 0; k < cmts_pkg::KW_NUM; k++) begin
      if (cnt >= CNT_W'(cmts_pkg::KW_LEN[k]) || cmts_pkg::KW_TEXT[k][cnt[2:0]] != c) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic cmts_pkg::tok_kind_e id_kind(
    input logic [cmts_pkg::KW_NUM-1:0] km,
    input logic [CNT_W-1:0]            cnt
  );
    cmts_pkg::tok_kind_e r;
    r = cmts_pkg::TOK_ID;
    for (int k = cmts_pkg::KW_NUM - 1; k >= 0; k--) begin
      if (km[k] && cnt == CNT_W'(cmts_pkg::KW_LEN[k])) begin
        r = cmts_pkg::tok_kind_e'(5'(int'(cmts_pkg::TOK_IF) + k));
      end
    end
    return r;
  endfunction

  // scan from the start state; used for the first pass in the start state
  // and for the second pass after a token was closed
  always_comb begin
    sp.emit  = 1'b0;
    sp.kind  = cmts_pkg::TOK_ERROR;
    sp.len   = CNT_W'(1);
    sp.state = cmts_pkg::ST_START;
    sp.cnt   = '0;
    sp.km    = KM_ALL;
    if (eof_i) begin
      sp.emit = 1'b1;
      sp.kind = cmts_pkg::TOK_ENDFILE;
      sp.len  = '0;
    end else if (cmts_pkg::is_digit(ch_i)) begin
      sp.state = cmts_pkg::ST_NUM;
      sp.cnt   = CNT_W'(1);
    end else if (cmts_pkg::is_alpha(ch_i)) begin
      sp.state = cmts_pkg::ST_ID;
      sp.cnt   = CNT_W'(1);
      sp.km    = match_letter(KM_ALL, '0, ch_i);
    end else if (cmts_pkg::is_space(ch_i)) begin
      sp.state = cmts_pkg::ST_START;
    end else if (ch_i == cmts_pkg::CH_SLASH) begin
      sp.state = cmts_pkg::ST_SLASH;
    end else if (ch_i == cmts_pkg::CH_LT) begin
      sp.state = cmts_pkg::ST_LT;
    end else if (ch_i == cmts_pkg::CH_GT) begin
      sp.state = cmts_pkg::ST_GT;
    end else if (ch_i == cmts_pkg::CH_EQ) begin
      sp.state = cmts_pkg::ST_EQ;
    end else if (ch_i == cmts_pkg::CH_BANG) begin
      sp.state = cmts_pkg::ST_BANG;
    end else begin
      sp.emit = 1'b1;
      sp.kind = cmts_pkg::single_kind(ch_i);
    end
  end

  // first pass from the current state
  always_comb begin
    logic is_eq;
    is_eq    = !eof_i && ch_i == cmts_pkg::CH_EQ;
    p1.emit  = 1'b0;
    p1.kind  = cmts_pkg::TOK_ERROR;
    p1.len   = CNT_W'(1);
    p1.state = cmts_pkg::ST_START;
    p1.cnt   = '0;
    p1.km    = KM_ALL;
    rescan   = 1'b0;
    case (state_q)
      cmts_pkg::ST_LT: begin
        p1.emit = 1'b1;
        p1.kind = is_eq ? cmts_pkg::TOK_LE : cmts_pkg::TOK_LT;
        p1.len  = is_eq ? CNT_W'(2) : CNT_W'(1);
        rescan  = !is_eq;
      end
      cmts_pkg::ST_GT: begin
        p1.emit = 1'b1;
        p1.kind = is_eq ? cmts_pkg::TOK_GE : cmts_pkg::TOK_GT;
        p1.len  = is_eq ? CNT_W'(2) : CNT_W'(1);
        rescan  = !is_eq;
      end
      cmts_pkg::ST_EQ: begin
        p1.emit = 1'b1;
        p1.kind = is_eq ? cmts_pkg::TOK_EQ : cmts_pkg::TOK_ASSIGN;
        p1.len  = is_eq ? CNT_W'(2) : CNT_W'(1);
        rescan  = !is_eq;
      end
      cmts_pkg::ST_BANG: begin
        // a lone bang is an error and the byte is scanned again
        p1.emit = 1'b1;
        p1.kind = is_eq ? cmts_pkg::TOK_NE : cmts_pkg::TOK_ERROR;
        p1.len  = is_eq ? CNT_W'(2) : CNT_W'(1);
        rescan  = !is_eq;
      end
      cmts_pkg::ST_SLASH: begin
        if (!eof_i && ch_i == cmts_pkg::CH_STAR) begin
          p1.state = cmts_pkg::ST_COMMENT;
        end else begin
          p1.emit = 1'b1;
          p1.kind = cmts_pkg::TOK_OVER;
          rescan  = 1'b1;
        end
      end
      cmts_pkg::ST_COMMENT: begin
        if (eof_i) begin
          p1.emit = 1'b1;
          p1.kind = cmts_pkg::TOK_ENDFILE;
          p1.len  = '0;
        end else begin
          p1.state = (ch_i == cmts_pkg::CH_STAR) ? cmts_pkg::ST_COMMSTAR : cmts_pkg::ST_COMMENT;
        end
      end
      cmts_pkg::ST_COMMSTAR: begin
        if (eof_i) begin
          p1.emit = 1'b1;
          p1.kind = cmts_pkg::TOK_ENDFILE;
          p1.len  = '0;
        end else if (ch_i == cmts_pkg::CH_SLASH) begin
          p1.state = cmts_pkg::ST_START;
        end else if (ch_i == cmts_pkg::CH_STAR) begin
          p1.state = cmts_pkg::ST_COMMSTAR;
        end else begin
          p1.state = cmts_pkg::ST_COMMENT;
        end
      end
      cmts_pkg::ST_NUM: begin
        if (!eof_i && cmts_pkg::is_digit(ch_i)) begin
          p1.state = cmts_pkg::ST_NUM;
          p1.cnt   = (cnt_q < CNT_MAX) ? cnt_q + CNT_W'(1) : cnt_q;
          p1.km    = km_q;
        end else begin
          p1.emit = 1'b1;
          p1.kind = cmts_pkg::TOK_NUM;
          p1.len  = cnt_q;
          rescan  = 1'b1;
        end
      end
      cmts_pkg::ST_ID: begin
        if (!eof_i && cmts_pkg::is_alpha(ch_i)) begin
          p1.state = cmts_pkg::ST_ID;
          p1.cnt   = (cnt_q < CNT_MAX) ? cnt_q + CNT_W'(1) : cnt_q;
          p1.km    = match_letter(km_q, cnt_q, ch_i);
        end else begin
          p1.emit = 1'b1;
          p1.kind = id_kind(km_q, cnt_q);
          p1.len  = cnt_q;
          rescan  = 1'b1;
        end
      end
      default: begin
        p1 = sp;
      end
    endcase
  end

  always_comb begin
    two = p1.emit && rescan && sp.emit;

    state_d = rescan ? sp.state : p1.state;
    cnt_d   = rescan ? sp.cnt   : p1.cnt;
    km_d    = rescan ? sp.km    : p1.km;

    line_d = line_q;
    if (!eof_i && ch_i == cmts_pkg::CH_NL && line_q != '1) begin
      line_d = line_q + cmts_pkg::LINE_W'(1);
    end

    res_o.count = two ? 2'd2 : ((p1.emit || (rescan && sp.emit)) ? 2'd1 : 2'd0);

    res_o.tok0.kind   = p1.emit ? p1.kind : sp.kind;
    res_o.tok0.length = cmts_pkg::LEN_W'(p1.emit ? p1.len : sp.len);
    res_o.tok0.line   = line_q;
    res_o.tok0.last   = !two;

    res_o.tok1.kind   = sp.kind;
    res_o.tok1.length = cmts_pkg::LEN_W'(sp.len);
    res_o.tok1.line   = line_q;
    res_o.tok1.last   = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cmts_pkg::ST_START;
      cnt_q   <= '0;
      km_q    <= KM_ALL;
      line_q  <= cmts_pkg::LINE_W'(1);
    end else if (accept_i) begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      km_q    <= km_d;
      line_q  <= line_d;
    end
  end

endmodule

// ===== sv/cminus_token_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// C-minus token scanner unit
// Lexical scanner for C-minus source: one byte or end-of-file mark per
// request in, tokens with kind, length and line number out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one source byte per request in s_axis_tdata, with
//   s_axis_tuser set to mark end of file instead of a byte.
//   Master channel: one token per request; m_axis_tlast marks the last
//   token caused by one input request. A request gives zero, one or two
//   tokens (a byte that closes a pending token is scanned again).
//   Queue: the tokens of a request are written into the result queue
//   when its byte is taken; the master side reads from the queue head.
//   Throughput: one byte per cycle while s_axis_tready is high. Tokens
//   drain through a four-entry result queue at one per cycle while the
//   receiver is ready, so an input request that yields two tokens takes longer to drain.
//   s_axis_tready is high while the queue has room for two tokens; bytes
//   keep flowing while results wait, and a stalled receiver holds the
//   queue and finally the input.
//   Reset: scanner goes to the start state, line counter to one, queue
//   empties.
// ----------------------------------------------------------------------------
module cminus_token_scanner_unit #(
  parameter int MAX_TOKEN_LENGTH = cmts_pkg::MAX_TOKEN_LENGTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tuser,   // [0] end_of_file
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [4:0] token_kind, [10:5] token_length,
                                      // [26:11] line_number, [31:27] zero
  output logic        m_axis_tlast    // last
);

  localparam int PTR_W = $clog2(cmts_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(cmts_pkg::FIFO_DEPTH + 1);

  cmts_pkg::scan_res_t res;
  cmts_pkg::token_t    fifo_q [cmts_pkg::FIFO_DEPTH];
  cmts_pkg::token_t    head;
  logic [PTR_W-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                accept;
  logic                pop;
  logic [1:0]          push_n;

  assign accept = s_axis_tvalid && s_axis_tready;

  cmts_core #(
    .MAX_TOKEN_LENGTH(MAX_TOKEN_LENGTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .ch_i     (s_axis_tdata),
    .eof_i    (s_axis_tuser),
    .res_o    (res)
  );

  assign s_axis_tready = cnt_q <= CNT_W'(cmts_pkg::FIFO_DEPTH - 2);
  assign m_axis_tvalid = cnt_q != '0;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign head          = fifo_q[rd_ptr_q];
  assign m_axis_tdata  = {5'd0, head.line, head.length, head.kind};
  assign m_axis_tlast  = head.last;

  always_comb begin
    push_n   = accept ? res.count : 2'd0;
    wr_ptr_d = wr_ptr_q + PTR_W'(push_n);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop);
    cnt_d    = cnt_q + CNT_W'(push_n) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue payload; tok1 goes behind tok0
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= res.tok0;
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_ptr_q + PTR_W'(1)] <= res.tok1;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(cmts_pkg::FIFO_DEPTH))
    else $error("token queue overflow");

  a_pair_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.count == 2'd2 |-> !res.tok0.last && res.tok1.last)
    else $error("last flag wrong on token pair");

  a_eof_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && head.kind == cmts_pkg::TOK_ENDFILE |-> m_axis_tlast)
    else $error("end-of-file token not last of its request");

  a_token_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && res.count != 2'd0 |=> m_axis_tvalid)
    else $error("token lost after request");

endmodule
